### sv/gbd_pkg.sv
// gbd_pkg: shared types and constants for the glyph bold dilation block.
// No dependencies; used by gbd_cell, gbd_line_mem and glyph_bold_dilation.
`timescale 1ns / 1ps
`default_nettype none

package gbd_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int HSHIFT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HSHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSHIFT = 1'b1;

  localparam logic [HSHIFT_W-1:0] HSHIFT_RST = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  // per-beat control handed to every window cell
  typedef struct packed {
    logic step;  // a beat is accepted
    logic clr;   // row or glyph ends with this beat
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/glyph_bold_dilation.sv
// glyph_bold_dilation: top level; two window cells, previous-row memory and
// output register. Depends on gbd_pkg, gbd_cell and gbd_line_mem.
//
// channel | dir | beat when             | tdata        | tlast    | tuser
// in_     | in  | in_tvalid & in_tready | [7:0] pixel  | row_end  | [0] glyph_end
// out_    | out | out_tvalid&out_tready | [7:0] pixel  | row_last | [0] glyph_last,
//         |     |                       |              |          | [1] overflow
// cfg_    | in  | cfg_valid & cfg_ready | cfg_index 0 hshift, 1 vshift; cfg_data
//
// One pixel per clock while the output is not stalled; a result appears the cycle after its input beat.
// The output register and the registered read of the previous-row memory both capture on the input beat.
// in_tready is high while the output register is empty or being drained.
// Synchronous active-low reset; the row memory is not cleared, the stored
// row length guards every read. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module glyph_bold_dilation #(
  parameter int ROW_CAP = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] pixel_in
  input  wire logic                             in_tlast,   // row_end
  input  wire logic                             in_tuser,   // [0] glyph_end
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] pixel_out
  output logic                                  out_tlast,  // row_last
  output logic [1:0]                            out_tuser,  // [0] glyph_last, [1] overflow
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
  localparam int CW = $clog2(ROW_CAP + 1);
  localparam logic [CW-1:0] COL_MAX = CW'(ROW_CAP);

  logic [gbd_pkg::HSHIFT_W-1:0] hshift_r, hshift_nxt;
  logic                         vshift_r, vshift_nxt;

  logic [CW-1:0] col_r, col_nxt, col_inc;
  logic [CW-1:0] plen_r, plen_nxt;
  logic          first_r, first_nxt;
  logic          ovf_r, ovf_nxt;

  logic          ov_r, ov_nxt;
  gbd_pkg::pix_t hmax_r;
  logic          use_r, last_r, glast_r, oflag_r;

  logic               accept, row_done, in_range, ovf_now, use_above;
  gbd_pkg::cell_ctl_t ctl;
  gbd_pkg::pix_t      tap0, tap1, max0, hmax, above;

  assign cfg_ready = 1'b1;

  always_comb begin
    hshift_nxt = hshift_r;
    vshift_nxt = vshift_r;
    if (cfg_valid) begin
      case (cfg_index)
        gbd_pkg::CFG_HSHIFT: hshift_nxt = cfg_data[gbd_pkg::HSHIFT_W-1:0];
        gbd_pkg::CFG_VSHIFT: vshift_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !ov_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign row_done  = in_tlast || in_tuser;
  assign in_range  = col_r < COL_MAX;
  assign ovf_now   = ovf_r || !in_range;
  assign use_above = vshift_r && !first_r && (col_r < plen_r) && in_range;
  assign ctl       = '{step: accept, clr: row_done};

  gbd_cell u_cell0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .en      (hshift_r != 2'd0),
    .px_in   (in_tdata),
    .max_in  (in_tdata),
    .px_out  (tap0),
    .max_out (max0)
  );

  gbd_cell u_cell1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .en      (hshift_r[1]),
    .px_in   (tap0),
    .max_in  (max0),
    .px_out  (tap1),
    .max_out (hmax)
  );

  gbd_line_mem #(
    .DEPTH (ROW_CAP),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && in_range),
    .waddr (col_r[AW-1:0]),
    .wdata (hmax),
    .re    (accept),
    .raddr (col_r[AW-1:0]),
    .rdata (above)
  );

  always_comb begin
    col_inc   = in_range ? (col_r + CW'(1)) : col_r;
    col_nxt   = col_r;
    plen_nxt  = plen_r;
    first_nxt = first_r;
    ovf_nxt   = ovf_r;
    ov_nxt    = ov_r;
    if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (accept) begin
      ov_nxt  = 1'b1;
      col_nxt = col_inc;
      ovf_nxt = ovf_now;
      if (row_done) begin
        plen_nxt  = col_inc;
        col_nxt   = '0;
        first_nxt = 1'b0;
      end
      if (in_tuser) begin
        plen_nxt  = '0;
        first_nxt = 1'b1;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hshift_r <= gbd_pkg::HSHIFT_RST;
      vshift_r <= 1'b0;
      col_r    <= '0;
      plen_r   <= '0;
      first_r  <= 1'b1;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      hshift_r <= hshift_nxt;
      vshift_r <= vshift_nxt;
      col_r    <= col_nxt;
      plen_r   <= plen_nxt;
      first_r  <= first_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hmax_r  <= hmax;
      use_r   <= use_above;
      last_r  <= in_tlast;
      glast_r <= in_tuser;
      oflag_r <= ovf_now;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = (use_r && (above > hmax_r)) ? above : hmax_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {oflag_r, glast_r};

endmodule

`default_nettype wire

### sv/gbd_cell.sv
// gbd_cell: one tap of the horizontal max window; holds a past pixel,
// folds it into the running max and passes it on. Depends on gbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbd_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gbd_pkg::cell_ctl_t ctl,
  input  wire logic              en,
  input  wire gbd_pkg::pix_t     px_in,
  input  wire gbd_pkg::pix_t     max_in,
  output gbd_pkg::pix_t          px_out,
  output gbd_pkg::pix_t          max_out
);

  gbd_pkg::pix_t tap_r;
  gbd_pkg::pix_t tap_nxt;

  always_comb begin
    tap_nxt = tap_r;
    if (ctl.step) begin
      tap_nxt = ctl.clr ? '0 : px_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= tap_nxt;
    end
  end

  assign px_out  = tap_r;
  assign max_out = (en && (tap_r > max_in)) ? tap_r : max_in;

endmodule

`default_nettype wire

### sv/gbd_line_mem.sv
// gbd_line_mem: previous-row store, one write and one registered read port.
// Depends on gbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbd_line_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire gbd_pkg::pix_t wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output gbd_pkg::pix_t      rdata
);

  gbd_pkg::pix_t mem [DEPTH];
  gbd_pkg::pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write: same-edge write to the same column is not seen
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
